FILE: rtl/rvdx_pkg.sv
package rvdx_pkg;

    // Data memory geometry
    localparam int MEM_WORDS = 4096;
    localparam int MEM_AW    = $clog2(MEM_WORDS);

    // Register file reset contents that differ from zero
    localparam logic [31:0] RF_SP_INIT = 32'h0000_3ffc;
    localparam logic [31:0] RF_GP_INIT = 32'h0000_1800;
    localparam logic [4:0]  RF_SP      = 5'd2;
    localparam logic [4:0]  RF_GP      = 5'd3;
    localparam logic [4:0]  RF_A0      = 5'd10;
    localparam logic [4:0]  RF_A7      = 5'd17;

    // Major opcodes
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [31:0] ECALL_WORD = 32'h0000_0073;

    // funct7 codes
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // funct3 codes
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [2:0] F3_LB  = 3'd0;
    localparam logic [2:0] F3_LH  = 3'd1;
    localparam logic [2:0] F3_LW  = 3'd2;
    localparam logic [2:0] F3_LBU = 3'd4;
    localparam logic [2:0] F3_LHU = 3'd5;

    localparam logic [2:0] F3_SB = 3'd0;
    localparam logic [2:0] F3_SH = 3'd1;
    localparam logic [2:0] F3_SW = 3'd2;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // a7 service codes and reported classes
    localparam logic [31:0] A7_PRINT_INT = 32'd1;
    localparam logic [31:0] A7_PRINT_STR = 32'd4;
    localparam logic [31:0] A7_EXIT      = 32'd10;

    localparam logic [1:0] SYS_NONE      = 2'd0;
    localparam logic [1:0] SYS_PRINT_INT = 2'd1;
    localparam logic [1:0] SYS_PRINT_STR = 2'd2;
    localparam logic [1:0] SYS_EXIT      = 2'd3;

    typedef struct packed {
        logic        action;
        logic [31:0] instr_word;
        logic [31:0] preload_address;
        logic [31:0] preload_data;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_written;
        logic [4:0]  dest_index;
        logic [31:0] dest_value;
        logic [1:0]  syscall_kind;
        logic [31:0] syscall_arg;
        logic        unknown_instr;
    } t_out_beat;

    // Reset value of a register file entry
    function automatic logic [31:0] rf_init(input logic [4:0] idx);
        logic [31:0] v;
        v = '0;
        if (idx == RF_SP) v = RF_SP_INIT;
        if (idx == RF_GP) v = RF_GP_INIT;
        return v;
    endfunction

endpackage

FILE: rtl/rvdx_in_if.sv
interface rvdx_in_if;
    logic               valid;
    logic               ready;
    rvdx_pkg::t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/rvdx_out_if.sv
interface rvdx_out_if;
    logic                valid;
    logic                ready;
    rvdx_pkg::t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/rv32i_decode_execute_core.sv
// Channel | Dir | Fields
// i_in    | in  | action, instr_word, preload_address, preload_data
// o_out   | out | next_pc, reg_written, dest_index, dest_value, syscall_kind,
//         |     | syscall_arg, unknown_instr
//
// A beat is taken in the cycle its register operands are read; it executes in
// the next cycle. Non-load beats can follow back to back; a load then passes
// through a data memory read stage, and execute waits until it has left.
// Synchronous active-low reset clears the pipeline, PC and register valid bits;
// no clearing pass is needed. A full output register with o_out.ready low
// stalls non-load execution and the load result, and then input acceptance.
module rv32i_decode_execute_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rvdx_in_if.sink          i_in,
    rvdx_out_if.source       o_out
);
    localparam int DMW = rvdx_pkg::MEM_AW;

    // ---------------- pipeline state ----------------
    logic                r_v2, r_v3, r_ov;
    rvdx_pkg::t_in_beat  r2;
    logic [31:0]         r_pc;
    rvdx_pkg::t_out_beat r_out;
    logic [31:0]         r_rfv;
    logic [4:0]          r_ra, r_rb;
    logic                r_fa_hit, r_fb_hit;
    logic [31:0]         r_fa_val, r_fb_val;
    logic [2:0]          r3_f3;
    logic [1:0]          r3_off;
    logic [4:0]          r3_rd;
    logic [31:0]         r3_npc;

    logic        accept, out_free, adv2, adv3, load2;
    logic [4:0]  new_ra, new_rb;
    logic [31:0] qa, qb, a, b;
    logic        rf_we;
    logic [4:0]  rf_wa;
    logic [31:0] rf_wd;

    // ---------------- handshake ----------------
    assign out_free   = !r_ov || o_out.ready;
    assign adv3       = r_v3 && out_free;
    assign adv2       = r_v2 && !r_v3 && (load2 || out_free);
    assign i_in.ready = !r_v2 || adv2;
    assign accept     = i_in.valid && i_in.ready;

    // ecall reads a7 and a0 instead of rs1/rs2
    always_comb begin
        if (i_in.data.instr_word == rvdx_pkg::ECALL_WORD) begin
            new_ra = rvdx_pkg::RF_A7;
            new_rb = rvdx_pkg::RF_A0;
        end else begin
            new_ra = i_in.data.instr_word[19:15];
            new_rb = i_in.data.instr_word[24:20];
        end
    end

    // ---------------- register file: two read copies ----------------
    rvdx_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
        .i_clk(i_clk), .i_we(rf_we), .i_be(4'hf), .i_waddr(rf_wa), .i_wdata(rf_wd),
        .i_re(accept), .i_raddr(new_ra), .o_rdata(qa)
    );
    rvdx_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
        .i_clk(i_clk), .i_we(rf_we), .i_be(4'hf), .i_waddr(rf_wa), .i_wdata(rf_wd),
        .i_re(accept), .i_raddr(new_rb), .o_rdata(qb)
    );

    // operand select: forwarded write, stored word, or reset value
    always_comb begin
        if (r_fa_hit)          a = r_fa_val;
        else if (r_rfv[r_ra])  a = qa;
        else                   a = rvdx_pkg::rf_init(r_ra);
        if (r_fb_hit)          b = r_fb_val;
        else if (r_rfv[r_rb])  b = qb;
        else                   b = rvdx_pkg::rf_init(r_rb);
    end

    // ---------------- execute ----------------
    logic [31:0] ins, imm_i, imm_s, imm_b, imm_j, addr, nxt, val, arg;
    logic [6:0]  opc, f7;
    logic [4:0]  rd, sh;
    logic [2:0]  f3;
    logic        wr, unk, is_load, take;
    logic [1:0]  kind;
    logic        dm_we;
    logic [3:0]  dm_be;
    logic [31:0] dm_wd;
    logic [DMW-1:0] dm_addr;

    always_comb begin
        ins   = r2.instr_word;
        opc   = ins[6:0];
        rd    = ins[11:7];
        f3    = ins[14:12];
        sh    = ins[24:20];
        f7    = ins[31:25];
        imm_i = {{20{ins[31]}}, ins[31:20]};
        imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        addr  = a + ((opc == rvdx_pkg::OPC_STORE) ? imm_s : imm_i);
        nxt     = r_pc + 32'd4;
        val     = '0;
        wr      = 1'b0;
        unk     = 1'b0;
        is_load = 1'b0;
        take    = 1'b0;
        kind    = rvdx_pkg::SYS_NONE;
        arg     = '0;
        dm_we   = 1'b0;
        dm_be   = 4'hf;
        dm_wd   = b;
        dm_addr = addr[DMW+1:2];

        unique case (opc)
            rvdx_pkg::OPC_LUI: begin
                val = {ins[31:12], 12'd0};
                wr  = 1'b1;
            end
            rvdx_pkg::OPC_AUIPC: begin
                val = r_pc + {ins[31:12], 12'd0};
                wr  = 1'b1;
            end
            rvdx_pkg::OPC_JAL: begin
                val = r_pc + 32'd4;
                wr  = 1'b1;
                nxt = r_pc + imm_j;
            end
            rvdx_pkg::OPC_JALR: begin
                if (f3 != 3'd0) begin
                    unk = 1'b1;
                end else begin
                    val = r_pc + 32'd4;
                    wr  = 1'b1;
                    nxt = (a + imm_i) & ~32'd1;
                end
            end
            rvdx_pkg::OPC_BRANCH: begin
                unique case (f3)
                    rvdx_pkg::F3_BEQ:  take = (a == b);
                    rvdx_pkg::F3_BNE:  take = (a != b);
                    rvdx_pkg::F3_BLT:  take = ($signed(a) < $signed(b));
                    rvdx_pkg::F3_BGE:  take = !($signed(a) < $signed(b));
                    rvdx_pkg::F3_BLTU: take = (a < b);
                    rvdx_pkg::F3_BGEU: take = (a >= b);
                    default:           unk  = 1'b1;
                endcase
                if (take) nxt = r_pc + imm_b;
            end
            rvdx_pkg::OPC_LOAD: begin
                unique case (f3)
                    rvdx_pkg::F3_LB, rvdx_pkg::F3_LH, rvdx_pkg::F3_LW,
                    rvdx_pkg::F3_LBU, rvdx_pkg::F3_LHU: is_load = 1'b1;
                    default:                            unk     = 1'b1;
                endcase
            end
            rvdx_pkg::OPC_STORE: begin
                unique case (f3)
                    rvdx_pkg::F3_SB: begin
                        dm_we = 1'b1;
                        dm_be = 4'b0001 << addr[1:0];
                        dm_wd = {4{b[7:0]}};
                    end
                    rvdx_pkg::F3_SH: begin
                        dm_we = 1'b1;
                        dm_be = addr[1] ? 4'b1100 : 4'b0011;
                        dm_wd = {2{b[15:0]}};
                    end
                    rvdx_pkg::F3_SW: dm_we = 1'b1;
                    default:         unk   = 1'b1;
                endcase
            end
            rvdx_pkg::OPC_OPIMM: begin
                wr = 1'b1;
                unique case (f3)
                    rvdx_pkg::F3_ADD:  val = a + imm_i;
                    rvdx_pkg::F3_SLT:  val = {31'd0, $signed(a) < $signed(imm_i)};
                    rvdx_pkg::F3_SLTU: val = {31'd0, a < imm_i};
                    rvdx_pkg::F3_XOR:  val = a ^ imm_i;
                    rvdx_pkg::F3_OR:   val = a | imm_i;
                    rvdx_pkg::F3_AND:  val = a & imm_i;
                    rvdx_pkg::F3_SLL: begin
                        if (f7 == rvdx_pkg::F7_BASE) val = a << sh;
                        else                         unk = 1'b1;
                    end
                    default: begin
                        if (f7 == rvdx_pkg::F7_BASE)     val = a >> sh;
                        else if (f7 == rvdx_pkg::F7_ALT) val = 32'($signed(a) >>> sh);
                        else                             unk = 1'b1;
                    end
                endcase
                if (unk) wr = 1'b0;
            end
            rvdx_pkg::OPC_OP: begin
                wr = 1'b1;
                if (f7 == rvdx_pkg::F7_BASE) begin
                    unique case (f3)
                        rvdx_pkg::F3_ADD:  val = a + b;
                        rvdx_pkg::F3_SLL:  val = a << b[4:0];
                        rvdx_pkg::F3_SLT:  val = {31'd0, $signed(a) < $signed(b)};
                        rvdx_pkg::F3_SLTU: val = {31'd0, a < b};
                        rvdx_pkg::F3_XOR:  val = a ^ b;
                        rvdx_pkg::F3_SR:   val = a >> b[4:0];
                        rvdx_pkg::F3_OR:   val = a | b;
                        default:           val = a & b;
                    endcase
                end else if (f7 == rvdx_pkg::F7_ALT && f3 == rvdx_pkg::F3_ADD) begin
                    val = a - b;
                end else if (f7 == rvdx_pkg::F7_ALT && f3 == rvdx_pkg::F3_SR) begin
                    val = 32'($signed(a) >>> b[4:0]);
                end else begin
                    unk = 1'b1;
                    wr  = 1'b0;
                end
            end
            rvdx_pkg::OPC_SYSTEM: begin
                // operands hold a7 and a0 for the ecall word
                if (ins != rvdx_pkg::ECALL_WORD) begin
                    unk = 1'b1;
                end else begin
                    if (a == rvdx_pkg::A7_PRINT_INT)      kind = rvdx_pkg::SYS_PRINT_INT;
                    else if (a == rvdx_pkg::A7_PRINT_STR) kind = rvdx_pkg::SYS_PRINT_STR;
                    else if (a == rvdx_pkg::A7_EXIT)      kind = rvdx_pkg::SYS_EXIT;
                    if (kind != rvdx_pkg::SYS_NONE) arg = b;
                end
            end
            default: unk = 1'b1;
        endcase

        // preload overrides everything
        if (r2.action) begin
            nxt     = r_pc;
            val     = '0;
            wr      = 1'b0;
            unk     = 1'b0;
            is_load = 1'b0;
            kind    = rvdx_pkg::SYS_NONE;
            arg     = '0;
            dm_we   = 1'b1;
            dm_be   = 4'hf;
            dm_wd   = r2.preload_data;
            dm_addr = r2.preload_address[DMW+1:2];
        end
    end

    assign load2 = is_load;

    // ---------------- data memory ----------------
    logic [31:0] dm_q;

    rvdx_ram #(.WIDTH(32), .DEPTH(rvdx_pkg::MEM_WORDS)) u_dmem (
        .i_clk(i_clk), .i_we(adv2 && dm_we), .i_be(dm_be), .i_waddr(dm_addr),
        .i_wdata(dm_wd), .i_re(adv2 && is_load), .i_raddr(dm_addr), .o_rdata(dm_q)
    );

    // load alignment and extension
    logic [7:0]  ld_byte;
    logic [15:0] ld_half;
    logic [31:0] ld_val;

    always_comb begin
        case (r3_off)
            2'd0:    ld_byte = dm_q[7:0];
            2'd1:    ld_byte = dm_q[15:8];
            2'd2:    ld_byte = dm_q[23:16];
            default: ld_byte = dm_q[31:24];
        endcase
        ld_half = r3_off[1] ? dm_q[31:16] : dm_q[15:0];
        unique case (r3_f3)
            rvdx_pkg::F3_LB:  ld_val = {{24{ld_byte[7]}}, ld_byte};
            rvdx_pkg::F3_LH:  ld_val = {{16{ld_half[15]}}, ld_half};
            rvdx_pkg::F3_LBU: ld_val = {24'd0, ld_byte};
            rvdx_pkg::F3_LHU: ld_val = {16'd0, ld_half};
            default:          ld_val = dm_q;
        endcase
    end

    // ---------------- register file write port ----------------
    always_comb begin
        rf_we = 1'b0;
        rf_wa = rd;
        rf_wd = val;
        if (adv3) begin
            rf_we = (r3_rd != 5'd0);
            rf_wa = r3_rd;
            rf_wd = ld_val;
        end else if (adv2 && wr && rd != 5'd0) begin
            rf_we = 1'b1;
        end
    end

    // ---------------- result beat ----------------
    rvdx_pkg::t_out_beat res2, res3;

    always_comb begin
        res2.next_pc       = nxt;
        res2.reg_written   = wr && (rd != 5'd0);
        res2.dest_index    = res2.reg_written ? rd : 5'd0;
        res2.dest_value    = res2.reg_written ? val : 32'd0;
        res2.syscall_kind  = kind;
        res2.syscall_arg   = arg;
        res2.unknown_instr = unk;

        res3.next_pc       = r3_npc;
        res3.reg_written   = (r3_rd != 5'd0);
        res3.dest_index    = r3_rd;
        res3.dest_value    = res3.reg_written ? ld_val : 32'd0;
        res3.syscall_kind  = rvdx_pkg::SYS_NONE;
        res3.syscall_arg   = '0;
        res3.unknown_instr = 1'b0;
    end

    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_ov  <= 1'b0;
            r_pc  <= '0;
            r_rfv <= '0;
        end else begin
            if (accept)    r_v2 <= 1'b1;
            else if (adv2) r_v2 <= 1'b0;

            if (adv2 && is_load) r_v3 <= 1'b1;
            else if (adv3)       r_v3 <= 1'b0;

            if (adv3 || (adv2 && !is_load)) r_ov <= 1'b1;
            else if (o_out.ready)           r_ov <= 1'b0;

            if (adv2) r_pc <= nxt;

            if (rf_we) r_rfv[rf_wa] <= 1'b1;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r2   <= i_in.data;
            r_ra <= new_ra;
            r_rb <= new_rb;
            r_fa_hit <= rf_we && (rf_wa == new_ra);
            r_fb_hit <= rf_we && (rf_wa == new_rb);
            r_fa_val <= rf_wd;
            r_fb_val <= rf_wd;
        end else begin
            // late write while the beat waits in execute
            if (rf_we && rf_wa == r_ra) begin
                r_fa_hit <= 1'b1;
                r_fa_val <= rf_wd;
            end
            if (rf_we && rf_wa == r_rb) begin
                r_fb_hit <= 1'b1;
                r_fb_val <= rf_wd;
            end
        end

        if (adv2 && is_load) begin
            r3_f3  <= f3;
            r3_off <= addr[1:0];
            r3_rd  <= rd;
            r3_npc <= nxt;
        end

        if (adv3)                    r_out <= res3;
        else if (adv2 && !is_load)   r_out <= res2;
    end
endmodule

FILE: rtl/rvdx_ram.sv
module rvdx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [WIDTH/8-1:0]       i_be,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    localparam int LANES = WIDTH / 8;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // Byte-lane write, registered read (old data on collision)
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            if (i_we && i_be[l]) begin
                r_mem[i_waddr][l*8 +: 8] <= i_wdata[l*8 +: 8];
            end
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule
